@@ sv/smma_pkg.sv @@
// shared constants, codes and types of the small matrix multiply-accumulate block
package smma_pkg;

  // default geometry and number format
  localparam int DEF_MAX_ROWS   = 16;
  localparam int DEF_MAX_COLS   = 16;
  localparam int DEF_MAX_DEPTH  = 32;
  localparam int DEF_WORK_LIMIT = 4096;
  localparam int DEF_FRAC_BITS  = 24;

  // field widths
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 5;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int ROWS_W    = 5;
  localparam int DEPTH_W   = 6;
  localparam int COLS_W    = 5;
  localparam int CFG_IDX_W = 3;

  // register reset values
  localparam logic [ROWS_W-1:0]         RST_ROWS  = 5'd8;
  localparam logic [DEPTH_W-1:0]        RST_DEPTH = 6'd8;
  localparam logic [COLS_W-1:0]         RST_COLS  = 5'd8;
  localparam logic signed [DATA_W-1:0]  RST_ALPHA = 32'sh0100_0000;
  localparam logic signed [DATA_W-1:0]  RST_BETA  = 32'sh0000_0000;

  // saturation limits
  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE_A = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_B = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE_C = 3'd2;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_C  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_READ   = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK_SIZE,
    ST_CHECK_WORK,
    ST_MAC,
    ST_MAC_DRAIN,
    ST_ALPHA,
    ST_ALPHA_DRAIN,
    ST_BETA,
    ST_BETA_WAIT,
    ST_WRITE_BACK,
    ST_DONE
  } seq_state_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [1:0] {
    MUL_AB,
    MUL_ALPHA,
    MUL_BETA
  } mul_sel_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic     mul_fire;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     alpha_start;
    logic     t1_load;
    logic     t2_clr;
  } dp_ctrl_t;

  // datapath to sequencer status
  typedef struct packed {
    logic busy;
    logic alpha_last;
    logic sat;
  } dp_stat_t;

endpackage

@@ sv/small_matrix_multiply_accumulate.sv @@
// Small matrix multiply-accumulate, C = alpha*A*B + beta*C in signed fixed point with
// FRAC_BITS fraction bits. Element writes give no result word and leave the block
// ready for the next word; a read of C passes its word through the C store read
// register and then the result register. A compute request goes through the shape
// check and the work check, then for every C element through a K-term dot product,
// alpha scaling, a beta term when beta_gain is nonzero, and write-back. One 33x33
// multiplier is shared by the dot product, the three-piece alpha scaling and the
// beta term, and each store has one read port. The block takes no new word while a
// read or compute is in progress; the result register lets the next request in as
// soon as the result is loaded. Store contents are undefined until written.
module small_matrix_multiply_accumulate import smma_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int WORK_LIMIT = DEF_WORK_LIMIT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [IDX_W-1:0]         row_index,
  input  logic [IDX_W-1:0]         col_index,
  input  logic signed [DATA_W-1:0] element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     saturated
);

  localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
  localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
  localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int A_AW    = $clog2(A_DEPTH);
  localparam int B_AW    = $clog2(B_DEPTH);
  localparam int C_AW    = $clog2(C_DEPTH);
  localparam int ROW_IW  = $clog2(MAX_ROWS);
  localparam int COL_IW  = $clog2(MAX_COLS);
  localparam int DEP_IW  = $clog2(MAX_DEPTH);
  localparam int MN_W    = ROWS_W + COLS_W;
  localparam int WORK_W  = MN_W + DEPTH_W;

  // configuration registers
  logic [ROWS_W-1:0]         rows_used;
  logic [DEPTH_W-1:0]        depth_used;
  logic [COLS_W-1:0]         cols_used;
  logic signed [DATA_W-1:0]  alpha_gain;
  logic signed [DATA_W-1:0]  beta_gain;

  // stores
  logic signed [DATA_W-1:0]  a_mem [A_DEPTH];
  logic signed [DATA_W-1:0]  b_mem [B_DEPTH];
  logic signed [DATA_W-1:0]  c_mem [C_DEPTH];
  logic signed [DATA_W-1:0]  a_q;
  logic signed [DATA_W-1:0]  b_q;
  logic signed [DATA_W-1:0]  c_q;

  // sequencer
  seq_state_t                state;
  seq_state_t                state_next;
  dp_ctrl_t                  dp_ctrl;
  dp_stat_t                  dp_stat;
  logic signed [DATA_W-1:0]  dp_result;
  logic [ROW_IW-1:0]         i;
  logic [COL_IW-1:0]         j;
  logic [DEP_IW-1:0]         d;
  logic [ROW_IW-1:0]         m_last;
  logic [COL_IW-1:0]         n_last;
  logic [DEP_IW-1:0]         d_last;
  logic                      rd_v;
  logic                      reject;
  logic                      sat_any;
  logic                      sat_flag;
  logic [MN_W-1:0]           mn;
  logic                      rd_ok;
  logic                      dims_bad;
  logic                      work_big;
  logic                      last_elem;
  logic                      slot_free;
  logic                      out_load;
  logic                      in_accept;

  // input decode
  logic                      a_in_ok;
  logic                      b_in_ok;
  logic                      c_in_ok;
  logic                      a_we;
  logic                      b_we;
  logic                      c_we;
  logic                      c_re;
  logic                      mem_re;
  logic [A_AW-1:0]           a_waddr;
  logic [A_AW-1:0]           a_raddr;
  logic [B_AW-1:0]           b_waddr;
  logic [B_AW-1:0]           b_raddr;
  logic [C_AW-1:0]           c_in_addr;
  logic [C_AW-1:0]           c_elem_addr;
  logic [C_AW-1:0]           c_waddr;
  logic [C_AW-1:0]           c_raddr;
  logic signed [DATA_W-1:0]  c_wdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used  <= RST_ROWS;
      depth_used <= RST_DEPTH;
      cols_used  <= RST_COLS;
      alpha_gain <= RST_ALPHA;
      beta_gain  <= RST_BETA;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROWS:  rows_used  <= cfg_data[ROWS_W-1:0];
        CFG_DEPTH: depth_used <= cfg_data[DEPTH_W-1:0];
        CFG_COLS:  cols_used  <= cfg_data[COLS_W-1:0];
        CFG_ALPHA: alpha_gain <= cfg_data;
        CFG_BETA:  beta_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and range checks
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign a_in_ok = (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_DEPTH);
  assign b_in_ok = (int'(row_index) < MAX_DEPTH) && (int'(col_index) < MAX_COLS);
  assign c_in_ok = (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);

  // store addresses
  assign a_waddr     = A_AW'(int'(row_index) * MAX_DEPTH + int'(col_index));
  assign b_waddr     = B_AW'(int'(row_index) * MAX_COLS + int'(col_index));
  assign c_in_addr   = C_AW'(int'(row_index) * MAX_COLS + int'(col_index));
  assign a_raddr     = A_AW'(int'(i) * MAX_DEPTH + int'(d));
  assign b_raddr     = B_AW'(int'(d) * MAX_COLS + int'(j));
  assign c_elem_addr = C_AW'(int'(i) * MAX_COLS + int'(j));

  assign a_we   = in_accept && (req_type == REQ_WRITE_A) && a_in_ok;
  assign b_we   = in_accept && (req_type == REQ_WRITE_B) && b_in_ok;
  assign mem_re = (state == ST_MAC);

  // c store is shared by host words and write-back
  assign c_we    = (in_accept && (req_type == REQ_WRITE_C) && c_in_ok)
                   || (state == ST_WRITE_BACK);
  assign c_waddr = (state == ST_WRITE_BACK) ? c_elem_addr : c_in_addr;
  assign c_wdata = (state == ST_WRITE_BACK) ? dp_result : element_value;
  assign c_re    = (in_accept && (req_type == REQ_READ_C) && c_in_ok)
                   || (state == ST_MAC && d == '0);
  assign c_raddr = (state == ST_IDLE) ? c_in_addr : c_elem_addr;

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_waddr] <= element_value;
    end
    if (mem_re) begin
      a_q <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= element_value;
    end
    if (mem_re) begin
      b_q <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_q <= c_mem[c_raddr];
    end
  end

  // shape checks and loop bounds
  assign dims_bad = (rows_used == '0) || (cols_used == '0) || (depth_used == '0)
                    || (int'(rows_used) > MAX_ROWS) || (int'(cols_used) > MAX_COLS)
                    || (int'(depth_used) > MAX_DEPTH);
  assign work_big = (2 * int'(WORK_W'(mn) * WORK_W'(depth_used))) > WORK_LIMIT;

  assign m_last    = ROW_IW'(rows_used - 1'b1);
  assign n_last    = COL_IW'(cols_used - 1'b1);
  assign d_last    = DEP_IW'(depth_used - 1'b1);
  assign last_elem = (i == m_last) && (j == n_last);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath controls
  always_comb begin
    state_next      = state;
    dp_ctrl         = '0;
    dp_ctrl.mul_sel = MUL_AB;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (req_type)
            REQ_COMPUTE: state_next = ST_CHECK_SIZE;
            REQ_READ_C:  state_next = ST_READ;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CHECK_SIZE: begin
        state_next = dims_bad ? ST_DONE : ST_CHECK_WORK;
      end
      ST_CHECK_WORK: begin
        if (work_big) begin
          state_next = ST_DONE;
        end else begin
          dp_ctrl.acc_clr = 1'b1;
          state_next      = ST_MAC;
        end
      end
      ST_MAC: begin
        dp_ctrl.mul_fire = rd_v;
        if (d == d_last) begin
          state_next = ST_MAC_DRAIN;
        end
      end
      ST_MAC_DRAIN: begin
        dp_ctrl.mul_fire = rd_v;
        if (!rd_v && !dp_stat.busy) begin
          dp_ctrl.alpha_start = 1'b1;
          state_next          = ST_ALPHA;
        end
      end
      ST_ALPHA: begin
        dp_ctrl.mul_fire = 1'b1;
        dp_ctrl.mul_sel  = MUL_ALPHA;
        if (dp_stat.alpha_last) begin
          state_next = ST_ALPHA_DRAIN;
        end
      end
      ST_ALPHA_DRAIN: begin
        if (!dp_stat.busy) begin
          dp_ctrl.t1_load = 1'b1;
          if (beta_gain == '0) begin
            dp_ctrl.t2_clr = 1'b1;
            state_next     = ST_WRITE_BACK;
          end else begin
            state_next = ST_BETA;
          end
        end
      end
      ST_BETA: begin
        dp_ctrl.mul_fire = 1'b1;
        dp_ctrl.mul_sel  = MUL_BETA;
        state_next       = ST_BETA_WAIT;
      end
      ST_BETA_WAIT: begin
        state_next = ST_WRITE_BACK;
      end
      ST_WRITE_BACK: begin
        dp_ctrl.acc_clr = 1'b1;
        state_next      = last_elem ? ST_DONE : ST_MAC;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // loop counters, pipeline flag, saturation tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v     <= 1'b0;
      reject   <= 1'b0;
      sat_any  <= 1'b0;
      sat_flag <= 1'b0;
      i        <= '0;
      j        <= '0;
      d        <= '0;
    end else begin
      rd_v <= (state == ST_MAC);
      case (state)
        ST_CHECK_SIZE: begin
          reject <= dims_bad;
        end
        ST_CHECK_WORK: begin
          reject  <= work_big;
          sat_any <= 1'b0;
          i       <= '0;
          j       <= '0;
          d       <= '0;
        end
        ST_MAC: begin
          d <= d + 1'b1;
        end
        ST_WRITE_BACK: begin
          sat_any <= sat_any || dp_stat.sat;
          d       <= '0;
          if (j == n_last) begin
            j <= '0;
            if (i == m_last) begin
              sat_flag <= sat_any || dp_stat.sat;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // shape product and read range, held for later states
  always_ff @(posedge clk) begin
    if (state == ST_CHECK_SIZE) begin
      mn <= MN_W'(rows_used) * MN_W'(cols_used);
    end
    if (in_accept && req_type == REQ_READ_C) begin
      rd_ok <= c_in_ok;
    end
  end

  // result word register
  assign out_load = ((state == ST_READ) || (state == ST_DONE)) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      saturated <= sat_flag;
      if (state == ST_READ) begin
        status    <= STAT_READ;
        out_value <= rd_ok ? c_q : '0;
      end else begin
        status    <= reject ? STAT_REJECT : STAT_DONE;
        out_value <= '0;
      end
    end
  end

  smma_datapath #(
    .MAX_DEPTH (MAX_DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (dp_ctrl),
    .a_data     (a_q),
    .b_data     (b_q),
    .c_data     (c_q),
    .alpha_gain (alpha_gain),
    .beta_gain  (beta_gain),
    .stat       (dp_stat),
    .result     (dp_result)
  );

`ifndef NO_ASSERTIONS
  // store read data only flows during the dot product
  a_rd_phase: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (state == ST_MAC || state == ST_MAC_DRAIN))
    else $error("store read data outside dot product phase");

  // a result word only comes from a read or a finished compute
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_READ || $past(state) == ST_DONE))
    else $error("result word loaded from unexpected state");

  // write-back stays inside the configured region
  a_wb_region: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE_BACK) |-> (i <= m_last && j <= n_last))
    else $error("write-back outside used region");

  // alpha scaling starts with an empty multiplier pipeline
  a_alpha_clean: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_MAC_DRAIN && state == ST_ALPHA) |-> !dp_stat.busy)
    else $error("alpha scaling began with a product in flight");
`endif

endmodule

@@ sv/smma_datapath.sv @@
// shared multiplier datapath: dot product, alpha and beta scaling, rounding, saturation
module smma_datapath import smma_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_ctrl_t                 ctrl,
  input  logic signed [DATA_W-1:0] a_data,
  input  logic signed [DATA_W-1:0] b_data,
  input  logic signed [DATA_W-1:0] c_data,
  input  logic signed [DATA_W-1:0] alpha_gain,
  input  logic signed [DATA_W-1:0] beta_gain,
  output dp_stat_t                 stat,
  output logic signed [DATA_W-1:0] result
);

  localparam int ACC_W  = 2 * DATA_W + $clog2(MAX_DEPTH);
  localparam int NCH    = (ACC_W + DATA_W - 1) / DATA_W;
  localparam int CH_W   = $clog2(NCH);
  localparam int OP_W   = DATA_W + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int WIDE_W = ACC_W + OP_W;
  localparam int T1_W   = WIDE_W - 2 * FRAC_BITS;
  localparam int T2_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W  = ((T1_W > T2_W) ? T1_W : T2_W) + 1;
  localparam logic signed [WIDE_W-1:0] T1_HALF = WIDE_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] T2_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [ACC_W-1:0]      acc;
  logic signed [NCH*DATA_W-1:0] acc_ext;
  logic [CH_W-1:0]              chunk;
  logic [DATA_W-1:0]            chunk_bits;
  logic signed [OP_W-1:0]       mul_x;
  logic signed [OP_W-1:0]       mul_y;
  logic signed [PROD_W-1:0]     prod;
  logic                         mul_v;
  mul_sel_t                     mul_tag;
  logic signed [WIDE_W-1:0]     wide;
  logic signed [WIDE_W-1:0]     t1_sum;
  logic signed [PROD_W-1:0]     t2_sum;
  logic signed [T1_W-1:0]       t1;
  logic signed [T2_W-1:0]       t2;
  logic signed [SUM_W-1:0]      total;
  logic [SUM_W-DATA_W:0]        top_bits;
  logic                         fits;

  // accumulator split into 32-bit pieces, top piece signed
  assign acc_ext    = (NCH * DATA_W)'(acc);
  assign chunk_bits = acc_ext[chunk * DATA_W +: DATA_W];

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      MUL_ALPHA: begin
        if (chunk == CH_W'(NCH - 1)) begin
          mul_x = {chunk_bits[DATA_W-1], chunk_bits};
        end else begin
          mul_x = {1'b0, chunk_bits};
        end
        mul_y = {alpha_gain[DATA_W-1], alpha_gain};
      end
      MUL_BETA: begin
        mul_x = {c_data[DATA_W-1], c_data};
        mul_y = {beta_gain[DATA_W-1], beta_gain};
      end
      default: begin
        mul_x = {a_data[DATA_W-1], a_data};
        mul_y = {b_data[DATA_W-1], b_data};
      end
    endcase
  end

  // product register and its tag
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= ctrl.mul_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_fire) begin
      prod    <= mul_x * mul_y;
      mul_tag <= ctrl.mul_sel;
    end
  end

  // alpha piece counter, top piece first
  always_ff @(posedge clk) begin
    if (ctrl.alpha_start) begin
      chunk <= CH_W'(NCH - 1);
    end else if (ctrl.mul_fire && ctrl.mul_sel == MUL_ALPHA) begin
      chunk <= chunk - 1'b1;
    end
  end

  // round half up by keeping the upper bits after adding half an lsb
  assign t1_sum = wide + T1_HALF;
  assign t2_sum = prod + T2_HALF;

  // exact dot product, horner sum of alpha pieces, rounded terms
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (mul_v && mul_tag == MUL_AB) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctrl.alpha_start) begin
      wide <= '0;
    end else if (mul_v && mul_tag == MUL_ALPHA) begin
      wide <= (wide <<< DATA_W) + WIDE_W'(prod);
    end
    if (ctrl.t1_load) begin
      t1 <= t1_sum[WIDE_W-1:2*FRAC_BITS];
    end
    if (ctrl.t2_clr) begin
      t2 <= '0;
    end else if (mul_v && mul_tag == MUL_BETA) begin
      t2 <= t2_sum[PROD_W-1:FRAC_BITS];
    end
  end

  // final sum and saturation
  assign total    = SUM_W'(t1) + SUM_W'(t2);
  assign top_bits = total[SUM_W-1:DATA_W-1];
  assign fits     = (&top_bits) || (~|top_bits);

  always_comb begin
    if (fits) begin
      result = total[DATA_W-1:0];
    end else if (total[SUM_W-1]) begin
      result = SAT_NEG;
    end else begin
      result = SAT_POS;
    end
  end

  assign stat.busy       = mul_v;
  assign stat.alpha_last = (chunk == '0);
  assign stat.sat        = !fits;

endmodule
